// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with an active-low reset that disables it.
`define OKLE_ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("okle port check failed");

// The same, on the usual clock and reset names of this project.
`define OKLE_ASSERT(label, prop) \
    `OKLE_ASSERT_CLK(label, i_clk, i_rst_n, prop)

`endif

// ===== rtl/okle_pkg.sv =====
// Package of the ordered key list engine: sizes, codes, and request and result types.
package okle_pkg;

    localparam int DEPTH   = 32;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int KEY_W   = 32;
    localparam int PAY_W   = 64;
    localparam int REC_W   = KEY_W + PAY_W;

    localparam logic [3:0] OP_INSERT_AT      = 4'd0;
    localparam logic [3:0] OP_UPDATE_AT      = 4'd1;
    localparam logic [3:0] OP_DELETE_AT      = 4'd2;
    localparam logic [3:0] OP_SEARCH         = 4'd3;
    localparam logic [3:0] OP_SORT           = 4'd4;
    localparam logic [3:0] OP_INSERT_ORDERED = 4'd5;
    localparam logic [3:0] OP_CLEAR          = 4'd6;
    localparam logic [3:0] OP_APPEND         = 4'd7;
    localparam logic [3:0] OP_READ_AT        = 4'd8;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BADPOS   = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;

    typedef struct packed {
        logic [3:0]        opcode;
        logic [5:0]        position;
        logic signed [31:0] key;
        logic [63:0]       payload;
    } t_req;

    typedef struct packed {
        logic [2:0]        status;
        logic [5:0]        found_position;
        logic signed [31:0] read_key;
        logic [63:0]       read_payload;
        logic [5:0]        entry_count;
    } t_rsp;

endpackage

// ===== rtl/okle_if.sv =====
// Request and result channel interfaces of the ordered key list engine.
interface okle_req_if;
    import okle_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface okle_rsp_if;
    import okle_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/ordered_key_list_engine.sv =====
// Ordered key list engine: a sequencer over one record RAM of DEPTH entries.
// Clear, append-free rejects and update go from S_IDLE straight to S_DONE and the result
// register; insert and delete step through S_RD and S_CHK once per shifted entry, search
// and ordered insert once per entry visited, and sort is a selection sort; all are paced by the RAM port.
// Throughput: one request at a time; a new request is taken while the last result waits.
// Reset (synchronous, i_rst_n low) empties the list; RAM contents are left as they are.
module ordered_key_list_engine (
    input  logic       i_clk,
    input  logic       i_rst_n,
    okle_req_if.sink   i_req,
    okle_rsp_if.source o_rsp
);
    import okle_pkg::*;

    localparam int CW = (CNT_W + 1 > 7) ? CNT_W + 1 : 7;

    // Sequencer states, one-hot.
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RD   = 5'b00010,
        S_CHK  = 5'b00100,
        S_WR   = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    // What the sequencer is walking the RAM for.
    typedef enum logic [6:0] {
        M_SHUP = 7'b0000001,
        M_SHDN = 7'b0000010,
        M_READ = 7'b0000100,
        M_SRCH = 7'b0001000,
        M_FIND = 7'b0010000,
        M_SCAN = 7'b0100000,
        M_SWAP = 7'b1000000
    } t_mode;

    t_state r_state, n_state;
    t_mode  r_mode, n_mode;
    logic [CNT_W-1:0] r_len, n_len;
    logic [CNT_W-1:0] r_j, n_j, r_tgt, n_tgt, r_i, n_i, r_m, n_m;
    logic signed [KEY_W-1:0] r_key, n_key;
    logic [PAY_W-1:0] r_pay, n_pay;
    logic [REC_W-1:0] r_min, n_min, r_tmp, n_tmp;
    logic [2:0] r_st, n_st;
    logic [5:0] r_fpos, n_fpos;
    logic signed [KEY_W-1:0] r_rk, n_rk;
    logic [PAY_W-1:0] r_rp, n_rp;
    logic r_ov, n_ov;
    t_rsp r_out, n_out;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [REC_W-1:0]  ram_wdata, ram_rdata;

    logic [CW-1:0] lenw, posw, jw, iw_next;
    logic signed [KEY_W-1:0] rd_key, min_key;
    logic full, accept;

    okle_ram #(.WIDTH(REC_W), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign o_rsp.valid = r_ov;
    assign o_rsp.data  = r_out;

    assign lenw    = CW'(r_len);
    assign posw    = CW'(i_req.data.position);
    assign jw      = CW'(r_j);
    assign iw_next = CW'(r_i) + CW'(1);
    assign full    = (lenw >= CW'(DEPTH));
    assign rd_key  = ram_rdata[REC_W-1:PAY_W];
    assign min_key = r_min[REC_W-1:PAY_W];

    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        n_len   = r_len;
        n_j     = r_j;
        n_tgt   = r_tgt;
        n_i     = r_i;
        n_m     = r_m;
        n_key   = r_key;
        n_pay   = r_pay;
        n_min   = r_min;
        n_tmp   = r_tmp;
        n_st    = r_st;
        n_fpos  = r_fpos;
        n_rk    = r_rk;
        n_rp    = r_rp;
        n_ov    = r_ov && !o_rsp.ready;
        n_out   = r_out;
        ram_we    = 1'b0;
        ram_waddr = r_j[ADDR_W-1:0];
        ram_wdata = ram_rdata;
        ram_raddr = r_j[ADDR_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_st    = ST_OK;
                    n_fpos  = '0;
                    n_rk    = '0;
                    n_rp    = '0;
                    n_key   = i_req.data.key;
                    n_pay   = i_req.data.payload;
                    n_state = S_DONE;
                    case (i_req.data.opcode)
                        OP_INSERT_AT: begin
                            if (posw == '0 || posw > lenw + CW'(1)) begin
                                n_st = ST_BADPOS;
                            end else if (full) begin
                                n_st = ST_FULL;
                            end else begin
                                n_mode  = M_SHUP;
                                n_j     = r_len;
                                n_tgt   = CNT_W'(posw - CW'(1));
                                n_state = S_RD;
                            end
                        end
                        OP_UPDATE_AT, OP_DELETE_AT, OP_READ_AT: begin
                            if (r_len == '0) begin
                                n_st = ST_EMPTY;
                            end else if (posw == '0 || posw > lenw) begin
                                n_st = ST_BADPOS;
                            end else if (i_req.data.opcode == OP_UPDATE_AT) begin
                                ram_we    = 1'b1;
                                ram_waddr = ADDR_W'(posw - CW'(1));
                                ram_wdata = {i_req.data.key, i_req.data.payload};
                            end else if (i_req.data.opcode == OP_DELETE_AT) begin
                                n_mode  = M_SHDN;
                                n_j     = CNT_W'(posw - CW'(1));
                                n_state = S_RD;
                            end else begin
                                n_mode  = M_READ;
                                n_tgt   = CNT_W'(posw - CW'(1));
                                n_state = S_RD;
                            end
                        end
                        OP_SEARCH: begin
                            n_mode  = M_SRCH;
                            n_j     = '0;
                            n_state = S_RD;
                        end
                        OP_SORT: begin
                            if (lenw >= CW'(2)) begin
                                n_mode  = M_SCAN;
                                n_i     = '0;
                                n_j     = '0;
                                n_m     = '0;
                                n_state = S_RD;
                            end
                        end
                        OP_INSERT_ORDERED: begin
                            if (full) begin
                                n_st = ST_FULL;
                            end else begin
                                n_mode  = M_FIND;
                                n_j     = '0;
                                n_state = S_RD;
                            end
                        end
                        OP_CLEAR: begin
                            n_len = '0;
                        end
                        OP_APPEND: begin
                            if (full) begin
                                n_st = ST_FULL;
                            end else begin
                                n_mode  = M_SHUP;
                                n_j     = r_len;
                                n_tgt   = r_len;
                                n_state = S_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // Issue one RAM read, or finish the walk.
            S_RD: begin
                n_state = S_CHK;
                case (r_mode)
                    M_SHUP: begin
                        if (r_j == r_tgt) begin
                            ram_we    = 1'b1;
                            ram_waddr = r_tgt[ADDR_W-1:0];
                            ram_wdata = {r_key, r_pay};
                            n_len     = r_len + CNT_W'(1);
                            n_state   = S_DONE;
                        end else begin
                            ram_raddr = ADDR_W'(r_j - CNT_W'(1));
                        end
                    end
                    M_SHDN: begin
                        if (jw + CW'(1) >= lenw) begin
                            n_len   = r_len - CNT_W'(1);
                            n_state = S_DONE;
                        end else begin
                            ram_raddr = ADDR_W'(jw + CW'(1));
                        end
                    end
                    M_READ: begin
                        ram_raddr = r_tgt[ADDR_W-1:0];
                    end
                    M_SRCH: begin
                        if (r_j == r_len) begin
                            n_st    = ST_NOTFOUND;
                            n_state = S_DONE;
                        end
                    end
                    M_FIND: begin
                        if (r_j == r_len) begin
                            n_mode  = M_SHUP;
                            n_tgt   = r_j;
                            n_state = S_RD;
                        end
                    end
                    M_SCAN: begin
                        if (r_j == r_len) begin
                            if (r_m != r_i) begin
                                ram_raddr = r_i[ADDR_W-1:0];
                                n_mode    = M_SWAP;
                            end else if (iw_next + CW'(1) >= lenw) begin
                                n_state = S_DONE;
                            end else begin
                                n_i     = CNT_W'(iw_next);
                                n_j     = CNT_W'(iw_next);
                                n_state = S_RD;
                            end
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end

            // Read data is here: act on it.
            S_CHK: begin
                n_state = S_RD;
                case (r_mode)
                    M_SHUP: begin
                        ram_we = 1'b1;
                        n_j    = r_j - CNT_W'(1);
                    end
                    M_SHDN: begin
                        ram_we = 1'b1;
                        n_j    = r_j + CNT_W'(1);
                    end
                    M_READ: begin
                        n_fpos  = 6'(CW'(r_tgt) + CW'(1));
                        n_rk    = rd_key;
                        n_rp    = ram_rdata[PAY_W-1:0];
                        n_state = S_DONE;
                    end
                    M_SRCH: begin
                        if (rd_key == r_key) begin
                            n_fpos  = 6'(jw + CW'(1));
                            n_rk    = rd_key;
                            n_rp    = ram_rdata[PAY_W-1:0];
                            n_state = S_DONE;
                        end else begin
                            n_j = r_j + CNT_W'(1);
                        end
                    end
                    M_FIND: begin
                        if (!(rd_key < r_key)) begin
                            n_tgt  = r_j;
                            n_j    = r_len;
                            n_mode = M_SHUP;
                        end else begin
                            n_j = r_j + CNT_W'(1);
                        end
                    end
                    M_SCAN: begin
                        if (r_j == r_i || rd_key < min_key) begin
                            n_min = ram_rdata;
                            n_m   = r_j;
                        end
                        n_j = r_j + CNT_W'(1);
                    end
                    M_SWAP: begin
                        ram_we    = 1'b1;
                        ram_waddr = r_i[ADDR_W-1:0];
                        ram_wdata = r_min;
                        n_tmp     = ram_rdata;
                        n_state   = S_WR;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end

            // Second half of a swap, then the next sort pass or the end of the sort.
            S_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_m[ADDR_W-1:0];
                ram_wdata = r_tmp;
                n_mode    = M_SCAN;
                if (iw_next + CW'(1) >= lenw) begin
                    n_state = S_DONE;
                end else begin
                    n_i     = CNT_W'(iw_next);
                    n_j     = CNT_W'(iw_next);
                    n_m     = CNT_W'(iw_next);
                    n_state = S_RD;
                end
            end

            S_DONE: begin
                if (!r_ov || o_rsp.ready) begin
                    n_ov  = 1'b1;
                    n_out = '{status: r_st, found_position: r_fpos, read_key: r_rk,
                              read_payload: r_rp, entry_count: lenw[5:0]};
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_ov    <= n_ov;
        end
        r_mode <= n_mode;
        r_j    <= n_j;
        r_tgt  <= n_tgt;
        r_i    <= n_i;
        r_m    <= n_m;
        r_key  <= n_key;
        r_pay  <= n_pay;
        r_min  <= n_min;
        r_tmp  <= n_tmp;
        r_st   <= n_st;
        r_fpos <= n_fpos;
        r_rk   <= n_rk;
        r_rp   <= n_rp;
        r_out  <= n_out;
    end
endmodule

// ===== rtl/okle_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module okle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                  i_wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                  o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/okle_checker.sv =====
// Port-level checks of the ordered key list engine and their binding.
`include "assert_macros.svh"

module okle_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  i_status,
    input logic [5:0]  i_found_position,
    input logic [31:0] i_read_key,
    input logic [5:0]  i_entry_count
);
    import okle_pkg::*;

    `OKLE_ASSERT(a_hold, i_out_valid && !i_out_ready |=> i_out_valid)
    `OKLE_ASSERT(a_count, i_out_valid |-> 7'(i_entry_count) <= 7'(DEPTH))
    `OKLE_ASSERT(a_status, i_out_valid |-> i_status <= ST_EMPTY)
    `OKLE_ASSERT(a_miss, i_out_valid && i_status != ST_OK |-> i_found_position == 6'd0 && i_read_key == 32'd0)
endmodule

bind ordered_key_list_engine okle_checker u_okle_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_rsp.valid),
    .i_out_ready      (o_rsp.ready),
    .i_status         (o_rsp.data.status),
    .i_found_position (o_rsp.data.found_position),
    .i_read_key       (o_rsp.data.read_key),
    .i_entry_count    (o_rsp.data.entry_count)
);
